FILE: rtl/asym_tanh_cubic_waveshaper_assert.svh
// assertion macros shared by the waveshaper modules
`ifndef ASYM_TANH_CUBIC_WAVESHAPER_ASSERT_SVH
`define ASYM_TANH_CUBIC_WAVESHAPER_ASSERT_SVH

// same-cycle implication
`define ATCW_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atcw check failed");

// next-cycle implication
`define ATCW_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atcw check failed");

`endif

FILE: rtl/atcw_pkg.sv
// package: widths, fixed-point constants and tanh point generator
`default_nettype none
package atcw_pkg;

  localparam int SAMPLE_W               = 18;
  localparam int TDATA_W                = 24;
  localparam int DRIVE_W                = 15;
  localparam int S1_W                   = 26;
  localparam int TANH_TABLE_ENTRIES_DEF = 256;

  localparam logic [DRIVE_W-1:0] DRIVE_MIN   = 15'd1024;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX   = 15'd30720;
  localparam logic [DRIVE_W-1:0] DRIVE_RESET = 15'd15872;

  localparam int BIAS_IN_Q25  = 6710886;
  localparam int SPAN_Q25     = 134217728;
  localparam int BIAS_OUT_Q24 = 3187671;

  localparam logic signed [S1_W-1:0] ONE_Q24     = 26'sd16777216;
  localparam logic signed [S1_W-1:0] NEG_ONE_Q24 = -26'sd16777216;

  // unsigned quotient by shift and subtract, for table generation only
  function automatic longint unsigned atcw_udiv(input longint unsigned n,
                                                input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(|u|) in q.24 from y = |u|/8 in q30, negated when neg is set
  function automatic longint atcw_tanh_point(input longint unsigned y, input bit neg);
    longint unsigned term;
    longint unsigned sum;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    longint unsigned t;
    term = 64'd1 << 30;
    sum  = term;
    for (longint unsigned i = 1; i <= 13; i++) begin
      term = atcw_udiv((term * y) >> 30, i);
      sum  = sum + term;
    end
    e = atcw_udiv((64'd1 << 60) + (sum >> 1), sum);
    for (int j = 0; j < 4; j++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    num = ((64'd1 << 30) - e) << 24;
    den = (64'd1 << 30) + e;
    t   = atcw_udiv(num + (den >> 1), den);
    return neg ? -$signed(t) : $signed(t);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/asym_tanh_cubic_waveshaper.sv
// throughput: one sample per cycle; a stall on out_ fills empty stages before in_tready drops
// the pipeline depth is set by the drive multiply, table index, interpolation and three shaper multiplies
// reset (rst_n low, synchronous) empties the pipeline and sets drive gain to 15.5
// the tanh table is constant logic and needs no fill after reset
`default_nettype none
module asym_tanh_cubic_waveshaper
  import atcw_pkg::*;
#(
  parameter int TANH_TABLE_ENTRIES = TANH_TABLE_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,    // sample_in [17:0]
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,   // sample_out [17:0]
  input  wire logic               cfg_wr_en,
  input  wire logic [DRIVE_W-1:0] cfg_wr_data  // drive_gain q5.10
);

  logic [DRIVE_W-1:0] drive_r;
  logic [DRIVE_W-1:0] drive_nxt;

  // gain is held already clamped to its legal span
  always_comb begin
    if (cfg_wr_data < DRIVE_MIN) begin
      drive_nxt = DRIVE_MIN;
    end else if (cfg_wr_data > DRIVE_MAX) begin
      drive_nxt = DRIVE_MAX;
    end else begin
      drive_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= DRIVE_RESET;
    end else if (cfg_wr_en) begin
      drive_r <= drive_nxt;
    end
  end

  logic                       s1_valid;
  logic                       s1_ready;
  logic signed [S1_W-1:0]     s1;
  logic signed [SAMPLE_W-1:0] sample_out;

  atcw_tanh #(
    .TANH_TABLE_ENTRIES(TANH_TABLE_ENTRIES)
  ) u_tanh (
    .clk      (clk),
    .rst_n    (rst_n),
    .drive    (drive_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .sample_in($signed(in_tdata[SAMPLE_W-1:0])),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .s1_out   (s1)
  );

  atcw_shaper u_shaper (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s1_valid),
    .up_ready  (s1_ready),
    .s1_in     (s1),
    .dn_valid  (out_tvalid),
    .dn_ready  (out_tready),
    .sample_out(sample_out)
  );

  assign out_tdata = {{(TDATA_W - SAMPLE_W){1'b0}}, sample_out};

endmodule
`default_nettype wire

FILE: rtl/atcw_tanh.sv
// biased tanh stage: drive multiply, rom index, interpolation, output s1
`default_nettype none
`include "asym_tanh_cubic_waveshaper_assert.svh"
module atcw_tanh
  import atcw_pkg::*;
#(
  parameter int TANH_TABLE_ENTRIES = TANH_TABLE_ENTRIES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [DRIVE_W-1:0]         drive,
  input  wire logic                       up_valid,
  output logic                            up_ready,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  output logic                            dn_valid,
  input  wire logic                       dn_ready,
  output logic signed [S1_W-1:0]          s1_out
);

  localparam int STG = 6;
  localparam int KW  = $clog2(TANH_TABLE_ENTRIES);
  localparam int NW  = $clog2(TANH_TABLE_ENTRIES + 1);
  localparam int DW  = $clog2((1 << 27) / TANH_TABLE_ENTRIES + 2) + 1;
  localparam int PW  = 28 + NW;

  typedef struct packed {
    logic lo;
    logic hi;
  } sat_t;

  // interpolation tables: base point and rising step to the next
  logic signed [S1_W-1:0] base_tab  [TANH_TABLE_ENTRIES];
  logic [DW-1:0]          delta_tab [TANH_TABLE_ENTRIES];

  for (genvar gk = 0; gk < TANH_TABLE_ENTRIES; gk++) begin : g_pt
    localparam longint unsigned FN   = 64'(4 * TANH_TABLE_ENTRIES);
    localparam longint unsigned EK0  = 64'(8 * gk);
    localparam longint unsigned EK1  = 64'(8 * (gk + 1));
    localparam longint unsigned DIF0 = (EK0 < FN) ? FN - EK0 : EK0 - FN;
    localparam longint unsigned DIF1 = (EK1 < FN) ? FN - EK1 : EK1 - FN;
    localparam longint unsigned Y0   = (DIF0 << 27) / TANH_TABLE_ENTRIES;
    localparam longint unsigned Y1   = (DIF1 << 27) / TANH_TABLE_ENTRIES;
    localparam longint          P0   = atcw_tanh_point(Y0, EK0 < FN);
    localparam longint          P1   = atcw_tanh_point(Y1, EK1 < FN);
    assign base_tab[gk]  = S1_W'(P0);
    assign delta_tab[gk] = (P1 > P0) ? DW'(P1 - P0) : '0;
  end

  logic [STG-1:0] v_r;
  logic [STG-1:0] v_nxt;
  logic [STG-1:0] en;

  always_comb begin
    en[STG-1] = !v_r[STG-1] || dn_ready;
    for (int i = STG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt = {v_r[STG-2:0], up_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < STG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_nxt[i];
        end
      end
    end
  end

  // stage 0: drive product
  logic signed [33:0] p0_r;
  logic signed [33:0] p0_nxt;
  assign p0_nxt = 34'(sample_in) * 34'($signed({1'b0, drive}));

  // stage 1: bias and span offset
  logic signed [34:0] w1;
  logic [27:0]        w1_r;
  sat_t               flg1_r;
  assign w1 = 35'(p0_r) + 35'(BIAS_IN_Q25) + 35'(SPAN_Q25);

  // stage 2: table position
  logic [PW-1:0]      pos2;
  logic [KW-1:0]      k2_r;
  logic [27:0]        frac2_r;
  sat_t               flg2_r;
  assign pos2 = PW'(w1_r) * PW'(TANH_TABLE_ENTRIES);

  // stage 3: table read
  logic signed [S1_W-1:0] base3_r;
  logic [DW-1:0]          delta3_r;
  logic [27:0]            frac3_r;
  sat_t                   flg3_r;

  // stage 4: interpolation product
  logic [DW+27:0]         ip4_r;
  logic signed [S1_W-1:0] base4_r;
  sat_t                   flg4_r;

  // stage 5: saturate and remove output bias
  logic signed [26:0]     t5;
  logic signed [S1_W-1:0] s1_r;

  always_comb begin
    if (flg4_r.lo) begin
      t5 = 27'(NEG_ONE_Q24);
    end else if (flg4_r.hi) begin
      t5 = 27'(ONE_Q24);
    end else begin
      t5 = 27'(base4_r) + $signed(27'({1'b0, ip4_r[DW+27:28]}));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0_r <= p0_nxt;
    end
    if (en[1]) begin
      w1_r      <= w1[27:0];
      flg1_r.lo <= w1[34];
      flg1_r.hi <= !w1[34] && (w1[33:28] != '0);
    end
    if (en[2]) begin
      k2_r    <= pos2[28 +: KW];
      frac2_r <= pos2[27:0];
      flg2_r  <= flg1_r;
    end
    if (en[3]) begin
      base3_r  <= base_tab[k2_r];
      delta3_r <= delta_tab[k2_r];
      frac3_r  <= frac2_r;
      flg3_r   <= flg2_r;
    end
    if (en[4]) begin
      ip4_r   <= (DW + 28)'(delta3_r) * (DW + 28)'(frac3_r);
      base4_r <= base3_r;
      flg4_r  <= flg3_r;
    end
    if (en[5]) begin
      s1_r <= S1_W'(t5 - 27'(BIAS_OUT_Q24));
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[STG-1];
  assign s1_out   = s1_r;

  `ATCW_ASSERT_IMP(a_sat_excl, clk, rst_n, v_r[1], !(flg1_r.lo && flg1_r.hi))
  `ATCW_ASSERT_IMP(a_s1_range, clk, rst_n, v_r[STG-1],
    (s1_r >= NEG_ONE_Q24 - 26'sd3187671) && (s1_r <= ONE_Q24 - 26'sd3187671))
  `ATCW_ASSERT_NXT(a_s1_hold, clk, rst_n, v_r[STG-1] && !dn_ready,
    v_r[STG-1] && $stable(s1_r))

endmodule
`default_nettype wire

FILE: rtl/atcw_shaper.sv
// cubic soft clip and crossfade from s1 to the saturated q2.15 sample
`default_nettype none
`include "asym_tanh_cubic_waveshaper_assert.svh"
module atcw_shaper
  import atcw_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   up_valid,
  output logic                        up_ready,
  input  wire logic signed [S1_W-1:0] s1_in,
  output logic                        dn_valid,
  input  wire logic                   dn_ready,
  output logic signed [SAMPLE_W-1:0]  sample_out
);

  localparam int STG = 5;

  logic [STG-1:0] v_r;
  logic [STG-1:0] v_nxt;
  logic [STG-1:0] en;

  always_comb begin
    en[STG-1] = !v_r[STG-1] || dn_ready;
    for (int i = STG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt = {v_r[STG-2:0], up_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < STG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_nxt[i];
        end
      end
    end
  end

  // stage 0: clamp, mix weight, square
  logic signed [S1_W-1:0] a0;
  logic [S1_W-1:0]        abs0;
  logic [24:0]            m0;
  logic signed [51:0]     sq0;
  logic signed [S1_W-1:0] a0_r;
  logic [24:0]            m0_r;
  logic signed [S1_W-1:0] s10_r;
  logic [48:0]            sq0_r;

  always_comb begin
    if (s1_in > ONE_Q24) begin
      a0 = ONE_Q24;
    end else if (s1_in < NEG_ONE_Q24) begin
      a0 = NEG_ONE_Q24;
    end else begin
      a0 = s1_in;
    end
    abs0 = s1_in[S1_W-1] ? S1_W'(-s1_in) : S1_W'(s1_in);
    m0   = (abs0 > S1_W'(ONE_Q24)) ? 25'(ONE_Q24) : 25'(abs0);
    sq0  = 52'(a0) * 52'(a0);
  end

  // stage 1: cube
  logic [24:0]            a2;
  logic signed [51:0]     cu1_r;
  logic signed [S1_W-1:0] a1_r;
  logic [24:0]            m1_r;
  logic signed [S1_W-1:0] s11_r;
  assign a2 = 25'((sq0_r + 49'h800000) >> 24);

  // stage 2: cubic clip and difference to s1
  logic signed [51:0]     cur2;
  logic signed [S1_W-1:0] a3;
  logic signed [27:0]     tc2;
  logic signed [27:0]     diff2;
  logic signed [27:0]     diff2_r;
  logic [24:0]            m2_r;
  logic signed [S1_W-1:0] s12_r;

  always_comb begin
    cur2  = cu1_r + 52'sh800000;
    a3    = $signed(cur2[49:24]);
    tc2   = 28'(a1_r) + 28'(a1_r) + 28'(a1_r) - 28'(a3) + 28'sd1;
    diff2 = (tc2 >>> 1) - 28'(s11_r);
  end

  // stage 3: crossfade product
  logic signed [53:0]     mp3_r;
  logic signed [S1_W-1:0] s13_r;

  // stage 4: mix, q.24 to q.15, saturate
  logic signed [53:0]         mr4;
  logic signed [30:0]         y4;
  logic signed [21:0]         r4;
  logic signed [SAMPLE_W-1:0] smp4;
  logic signed [SAMPLE_W-1:0] out_r;

  always_comb begin
    mr4 = mp3_r + 54'sh800000;
    y4  = 31'($signed(mr4[53:24])) + 31'(s13_r) + 31'sd256;
    r4  = $signed(y4[30:9]);
    if (r4 > 22'sd131071) begin
      smp4 = 18'sd131071;
    end else if (r4 < -22'sd131072) begin
      smp4 = -18'sd131072;
    end else begin
      smp4 = SAMPLE_W'(r4);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0_r  <= a0;
      m0_r  <= m0;
      s10_r <= s1_in;
      sq0_r <= sq0[48:0];
    end
    if (en[1]) begin
      cu1_r <= 52'($signed({1'b0, a2})) * 52'(a0_r);
      a1_r  <= a0_r;
      m1_r  <= m0_r;
      s11_r <= s10_r;
    end
    if (en[2]) begin
      diff2_r <= diff2;
      m2_r    <= m1_r;
      s12_r   <= s11_r;
    end
    if (en[3]) begin
      mp3_r <= 54'($signed({1'b0, m2_r})) * 54'(diff2_r);
      s13_r <= s12_r;
    end
    if (en[4]) begin
      out_r <= smp4;
    end
  end

  assign up_ready   = en[0];
  assign dn_valid   = v_r[STG-1];
  assign sample_out = out_r;

  `ATCW_ASSERT_IMP(a_clip_range, clk, rst_n, v_r[0],
    (a0_r <= ONE_Q24) && (a0_r >= NEG_ONE_Q24))
  `ATCW_ASSERT_IMP(a_mix_range, clk, rst_n, v_r[0], m0_r <= 25'(ONE_Q24))
  `ATCW_ASSERT_IMP(a_sq_range, clk, rst_n, v_r[0], sq0_r <= (49'd1 << 48))

endmodule
`default_nettype wire
